// ===== hw/rtl/bsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared constants, types and the divider step for the barometric sensor
// compensation pipeline.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_IDX_W-1:0] REG_TEMP_COEF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_HIGH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_LAST = 2'd3;

    localparam int FRONT_STAGES = 9;
    localparam int DIV_STEPS    = 64;
    localparam int BACK_STAGES  = 5;
    localparam int LATENCY      = FRONT_STAGES + DIV_STEPS + BACK_STAGES;

    localparam int TEMP_MIN_CENTI = -4000;
    localparam int TEMP_MAX_CENTI = 8500;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;

    typedef struct packed {
        logic [30:0]        rem;
        logic [63:0]        qd;
        logic [30:0]        md;
        logic               qneg;
        logic               err;
        logic signed [14:0] tc;
    } div_stage_t;

    // One restoring division step: the next dividend bit leaves the top of qd
    // and the new quotient bit enters at its bottom.
    function automatic div_stage_t div_step(input div_stage_t s);
        div_stage_t  r;
        logic [31:0] trial;
        logic [31:0] dsor;
        r     = s;
        trial = {s.rem, s.qd[63]};
        dsor  = {1'b0, s.md};
        if (trial >= dsor)
        begin
            r.rem = 31'(trial - dsor);
            r.qd  = {s.qd[62:0], 1'b1};
        end
        else
        begin
            r.rem = trial[30:0];
            r.qd  = {s.qd[62:0], 1'b0};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/barometric_sensor_compensation.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// barometric_sensor_compensation
// Pipelined temperature and pressure compensation of raw barometer readings.
// ----------------------------------------------------------------------------
// Each input transaction on s_axis carries one raw pressure and one raw
// temperature reading. Each output transaction on m_axis carries the
// compensated temperature in hundredths of a degree, the pressure in pascal
// as unsigned Q24.8, and in tuser a flag that marks a zero pressure divisor.
// Calibration coefficients are to be written through the cfg port only while
// no transaction is in flight; the block itself does not enforce this.
// A new reading pair is accepted every cycle while the output is not
// stalled. A transaction passes through 9 stages of temperature and
// pressure polynomial, 64 stages of a radix-2 divider that forms one
// quotient bit per stage, and 5 stages of correction terms ending in the
// output register.
// Reset clears the coefficients to zero and empties the pipeline.
// When the receiver stalls, the whole pipeline holds and s_axis_tready
// drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wen,
    input  wire logic [bsc_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [bsc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0: raw_pressure[19:0], raw_temperature[39:20].
    input  wire logic [bsc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // Fields from bit 0: temperature_centi[14:0], pressure_q24_8[46:15], zero pad.
    output logic [bsc_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // Fields from bit 0: divide_error.
    output logic                                 m_axis_tuser
);
    import bsc_pkg::*;

    logic [47:0] temp_coef_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_high_reg;
    logic [15:0] press_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coef_reg  <= '0;
            press_low_reg  <= '0;
            press_high_reg <= '0;
            press_last_reg <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_addr)
                REG_TEMP_COEF:  temp_coef_reg  <= cfg_wdata[47:0];
                REG_PRESS_LOW:  press_low_reg  <= cfg_wdata;
                REG_PRESS_HIGH: press_high_reg <= cfg_wdata;
                REG_PRESS_LAST: press_last_reg <= cfg_wdata[15:0];
                default:        ;
            endcase
        end
    end

    logic [15:0]        t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = temp_coef_reg[15:0];
    assign t2 = $signed(temp_coef_reg[31:16]);
    assign t3 = $signed(temp_coef_reg[47:32]);
    assign p1 = press_low_reg[15:0];
    assign p2 = $signed(press_low_reg[31:16]);
    assign p3 = $signed(press_low_reg[47:32]);
    assign p4 = $signed(press_low_reg[63:48]);
    assign p5 = $signed(press_high_reg[15:0]);
    assign p6 = $signed(press_high_reg[31:16]);
    assign p7 = $signed(press_high_reg[47:32]);
    assign p8 = $signed(press_high_reg[63:48]);
    assign p9 = $signed(press_last_reg);

    logic               en;
    logic [LATENCY-1:0] vld_reg;

    assign en            = !vld_reg[LATENCY-1] || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LATENCY-2:0], s_axis_tvalid};
    end

    // Stage 1
    logic signed [17:0] v1;
    logic signed [16:0] d1;
    logic signed [33:0] pa_next, ddw;
    logic signed [33:0] pa_reg;
    logic [31:0]        dd_reg;
    logic [20:0]        pr0_1_reg;

    assign v1      = $signed({1'b0, s_axis_tdata[39:23]}) - $signed({1'b0, t1, 1'b0});
    assign d1      = $signed({1'b0, s_axis_tdata[39:24]}) - $signed({1'b0, t1});
    assign pa_next = 34'(v1) * 34'(t2);
    assign ddw     = 34'(d1) * 34'(d1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg    <= pa_next;
            dd_reg    <= ddw[31:0];
            pr0_1_reg <= 21'h100000 - {1'b0, s_axis_tdata[19:0]};
        end
    end

    // Stage 2
    logic signed [36:0] bt_next, bt_reg;
    logic signed [22:0] at_reg;
    logic [20:0]        pr0_2_reg;

    assign bt_next = 37'($signed({1'b0, dd_reg[31:12]})) * 37'(t3);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            at_reg    <= $signed(pa_reg[33:11]);
            bt_reg    <= bt_next;
            pr0_2_reg <= pr0_1_reg;
        end
    end

    // Stage 3
    logic signed [23:0] tf_reg;
    logic [20:0]        pr0_3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tf_reg    <= 24'(at_reg) + 24'($signed(bt_reg[36:14]));
            pr0_3_reg <= pr0_2_reg;
        end
    end

    // Stage 4
    logic signed [24:0] x_next, x_reg;
    logic signed [49:0] xxw;
    logic signed [26:0] tcw;
    logic signed [18:0] tcs;
    logic signed [14:0] tc_next, tc_4_reg;
    logic [47:0]        xx_reg;
    logic [20:0]        pr0_4_reg;

    assign x_next = 25'(tf_reg) - 25'sd128000;
    assign xxw    = 50'(x_next) * 50'(x_next);
    assign tcw    = 27'(tf_reg) * 27'sd5 + 27'sd128;
    assign tcs    = $signed(tcw[26:8]);

    always_comb
    begin
        if (tcs < 19'(TEMP_MIN_CENTI))
            tc_next = 15'(TEMP_MIN_CENTI);
        else if (tcs > 19'(TEMP_MAX_CENTI))
            tc_next = 15'(TEMP_MAX_CENTI);
        else
            tc_next = tcs[14:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg     <= x_next;
            xx_reg    <= xxw[47:0];
            tc_4_reg  <= tc_next;
            pr0_4_reg <= pr0_3_reg;
        end
    end

    // Stage 5
    logic signed [48:0] xs;
    logic signed [63:0] bp6_reg, ap3_reg;
    logic signed [40:0] bp5_reg, ap2_reg;
    logic signed [14:0] tc_5_reg;
    logic [20:0]        pr0_5_reg;

    assign xs = $signed({1'b0, xx_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bp6_reg   <= 64'(xs) * 64'(p6);
            ap3_reg   <= 64'(xs) * 64'(p3);
            bp5_reg   <= 41'(x_reg) * 41'(p5);
            ap2_reg   <= 41'(x_reg) * 41'(p2);
            tc_5_reg  <= tc_4_reg;
            pr0_5_reg <= pr0_4_reg;
        end
    end

    // Stage 6
    logic signed [63:0] bsum_reg, u_reg;
    logic signed [14:0] tc_6_reg;
    logic [20:0]        pr0_6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bsum_reg  <= bp6_reg + (64'(bp5_reg) <<< 17) + (64'(p4) <<< 35);
            u_reg     <= (ap3_reg >>> 8) + (64'(ap2_reg) <<< 12)
                         + 64'sh0000_8000_0000_0000;
            tc_6_reg  <= tc_5_reg;
            pr0_6_reg <= pr0_5_reg;
        end
    end

    // Stage 7
    logic signed [63:0] prod7, num0_reg;
    logic signed [30:0] adiv_7_reg;
    logic signed [14:0] tc_7_reg;

    assign prod7 = u_reg * 64'($signed({1'b0, p1}));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            adiv_7_reg <= $signed(prod7[63:33]);
            num0_reg   <= $signed({12'b0, pr0_6_reg, 31'b0}) - bsum_reg;
            tc_7_reg   <= tc_6_reg;
        end
    end

    // Stage 8
    logic signed [63:0] num_reg;
    logic signed [30:0] adiv_8_reg;
    logic signed [14:0] tc_8_reg;
    logic               err_8_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg    <= num0_reg * 64'sd3125;
            adiv_8_reg <= adiv_7_reg;
            err_8_reg  <= (adiv_7_reg == '0);
            tc_8_reg   <= tc_7_reg;
        end
    end

    // Stage 9: magnitudes and quotient sign for the divider.
    div_stage_t prep_next, prep_reg;

    always_comb
    begin
        prep_next.rem  = '0;
        prep_next.qd   = num_reg[63] ? 64'(-num_reg) : num_reg;
        prep_next.md   = adiv_8_reg[30] ? 31'(-adiv_8_reg) : adiv_8_reg;
        prep_next.qneg = num_reg[63] ^ adiv_8_reg[30];
        prep_next.err  = err_8_reg;
        prep_next.tc   = tc_8_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            prep_reg <= prep_next;
    end

    div_stage_t div_reg [DIV_STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg[0] <= div_step(prep_reg);
            for (int k = 1; k < DIV_STEPS; k++)
                div_reg[k] <= div_step(div_reg[k-1]);
        end
    end

    // Back stage 1: signed quotient.
    logic [63:0]        qmag;
    logic signed [63:0] prq, pr_q_reg, s_reg;
    logic signed [14:0] tc_q_reg;
    logic               err_q_reg;

    assign qmag = div_reg[DIV_STEPS-1].qd;
    assign prq  = div_reg[DIV_STEPS-1].qneg ? $signed(-qmag) : $signed(qmag);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_q_reg  <= prq;
            s_reg     <= prq >>> 13;
            tc_q_reg  <= div_reg[DIV_STEPS-1].tc;
            err_q_reg <= div_reg[DIV_STEPS-1].err;
        end
    end

    // Back stage 2: square of the scaled quotient in 32-bit halves.
    logic [31:0]        sl, sh;
    logic [63:0]        lhw, ll_reg;
    logic signed [63:0] b8w, b8_m1_reg, pr_m1_reg;
    logic [30:0]        lh_reg;
    logic signed [14:0] tc_m1_reg;
    logic               err_m1_reg;

    assign sl  = s_reg[31:0];
    assign sh  = s_reg[63:32];
    assign lhw = 64'(sl) * 64'(sh);
    assign b8w = pr_q_reg * 64'(p8);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg     <= 64'(sl) * 64'(sl);
            lh_reg     <= lhw[30:0];
            b8_m1_reg  <= b8w >>> 19;
            pr_m1_reg  <= pr_q_reg;
            tc_m1_reg  <= tc_q_reg;
            err_m1_reg <= err_q_reg;
        end
    end

    // Back stage 3
    logic [63:0]        m_reg;
    logic signed [63:0] b8_m2_reg, pr_m2_reg;
    logic signed [14:0] tc_m2_reg;
    logic               err_m2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg      <= ll_reg + {lh_reg, 33'b0};
            b8_m2_reg  <= b8_m1_reg;
            pr_m2_reg  <= pr_m1_reg;
            tc_m2_reg  <= tc_m1_reg;
            err_m2_reg <= err_m1_reg;
        end
    end

    // Back stage 4
    logic signed [63:0] pm, a2_reg, b8_m3_reg, pr_m3_reg;
    logic signed [14:0] tc_m3_reg;
    logic               err_m3_reg;

    assign pm = $signed(m_reg) * 64'(p9);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a2_reg     <= pm >>> 25;
            b8_m3_reg  <= b8_m2_reg;
            pr_m3_reg  <= pr_m2_reg;
            tc_m3_reg  <= tc_m2_reg;
            err_m3_reg <= err_m2_reg;
        end
    end

    // Back stage 5: final sum, clamp and output register.
    logic signed [63:0] sumw, fin;
    logic [31:0]        p_next;
    logic [31:0]        out_p_reg;
    logic signed [14:0] out_tc_reg;
    logic               out_err_reg;

    assign sumw = pr_m3_reg + a2_reg + b8_m3_reg;
    assign fin  = (sumw >>> 8) + (64'(p7) <<< 4);

    always_comb
    begin
        if (err_m3_reg || fin[63])
            p_next = '0;
        else if (|fin[62:32])
            p_next = '1;
        else
            p_next = fin[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_p_reg   <= p_next;
            out_tc_reg  <= tc_m3_reg;
            out_err_reg <= err_m3_reg;
        end
    end

    assign m_axis_tvalid = vld_reg[LATENCY-1];
    assign m_axis_tdata  = {1'b0, out_p_reg, out_tc_reg};
    assign m_axis_tuser  = out_err_reg;

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("Input accepted while the output is stalled.");

    a_error_zero_pressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[46:15] == '0)
        else $error("Divide error with nonzero pressure.");

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[14:0]) >= 15'(TEMP_MIN_CENTI))
                       && ($signed(m_axis_tdata[14:0]) <= 15'(TEMP_MAX_CENTI)))
        else $error("Temperature outside its saturation range.");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the barometric sensor compensation pipeline.
// ----------------------------------------------------------------------------
// Readings stream in on s_axis and results come back on m_axis. Each accepted
// reading is run through a bit-exact model of the fixed-point compensation.
// The model uses the coefficients that the bench last wrote. Each result is
// compared with the oldest prediction. The run walks through several
// coefficient sets: reset values, typical calibration, extremes and random
// words. Random gaps and stalls are placed on both streams.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bsc_pkg::*;

    typedef struct {
        logic signed [14:0] tc;
        logic [31:0]        press;
        logic               err;
    } reading_t;

    typedef struct {
        logic [19:0] rp;
        logic [19:0] rt;
        logic        lit;
        reading_t    want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic m_axis_tuser;

    logic [47:0] temp_cf = '0;
    logic [63:0] plow_cf = '0;
    logic [63:0] phigh_cf = '0;
    logic [15:0] p9_cf = '0;

    reading_t expected_q[$];
    reading_t literal_q[$];
    logic     literal_use_q[$];
    int       mismatches = 0;
    bit       no_idle = 1'b0;
    int       stall_cnt = 0;

    barometric_sensor_compensation uut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #400000;
        $display("tb failed");
        $finish;
    end

    function automatic logic [63:0] shr(input logic [63:0] v, input int n);
        logic signed [63:0] s;
        s = v;
        return 64'(s >>> n);
    endfunction

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] div_trunc(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] q;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        q = ma / mb;
        return (a[63] ^ b[63]) ? -q : q;
    endfunction

    function automatic reading_t compensate(input logic [19:0] rp, input logic [19:0] rt);
        reading_t r;
        logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] a, b, d, tf, x, pr, at;
        logic signed [63:0] tcs;
        logic signed [63:0] ps;
        at = 64'(rt);
        t1 = 64'(temp_cf[15:0]);
        t2 = sx16(temp_cf[31:16]);
        t3 = sx16(temp_cf[47:32]);
        p1 = 64'(plow_cf[15:0]);
        p2 = sx16(plow_cf[31:16]);
        p3 = sx16(plow_cf[47:32]);
        p4 = sx16(plow_cf[63:48]);
        p5 = sx16(phigh_cf[15:0]);
        p6 = sx16(phigh_cf[31:16]);
        p7 = sx16(phigh_cf[47:32]);
        p8 = sx16(phigh_cf[63:48]);
        p9 = sx16(p9_cf);
        a = shr(((at >> 3) - (t1 << 1)) * t2, 11);
        d = (at >> 4) - t1;
        b = shr(shr(d * d, 12) * t3, 14);
        tf = a + b;
        tcs = shr(tf * 64'd5 + 64'd128, 8);
        if (tcs < TEMP_MIN_CENTI)
            tcs = TEMP_MIN_CENTI;
        if (tcs > TEMP_MAX_CENTI)
            tcs = TEMP_MAX_CENTI;
        r.tc = tcs[14:0];
        r.press = '0;
        r.err = 1'b0;
        x = tf - 64'd128000;
        b = x * x * p6;
        b = b + ((x * p5) << 17);
        b = b + (p4 << 35);
        a = shr(x * x * p3, 8) + ((x * p2) << 12);
        a = shr(((64'd1 << 47) + a) * p1, 33);
        if (a == 64'd0)
            r.err = 1'b1;
        else
        begin
            pr = 64'd1048576 - 64'(rp);
            pr = div_trunc(((pr << 31) - b) * 64'd3125, a);
            a = shr(p9 * shr(pr, 13) * shr(pr, 13), 25);
            b = shr(p8 * pr, 19);
            pr = shr(pr + a + b, 8) + (p7 << 4);
            ps = pr;
            if (ps < 0)
                r.press = '0;
            else if (ps > 64'sh0FFFFFFFF)
                r.press = 32'hFFFFFFFF;
            else
                r.press = ps[31:0];
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk)
    begin
        if (stall_cnt > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_cnt <= stall_cnt - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            stall_cnt <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        reading_t got;
        reading_t want;
        logic use_lit;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            want = compensate(s_axis_tdata[19:0], s_axis_tdata[39:20]);
            if (literal_q.size() > 0)
            begin
                use_lit = literal_use_q.pop_front();
                got = literal_q.pop_front();
                if (use_lit)
                    want = got;
            end
            expected_q.push_back(want);
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.tc = m_axis_tdata[14:0];
            got.press = m_axis_tdata[46:15];
            got.err = m_axis_tuser;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: tc=%0d p=%h err=%b",
                             got.tc, got.press, got.err);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.tc !== want.tc || got.press !== want.press || got.err !== want.err)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: tc exp %0d got %0d, p exp %h got %h, err exp %b got %b",
                                 want.tc, got.tc, want.press, got.press, want.err, got.err);
                end
            end
        end
    end

    task automatic send_reading(input logic [19:0] rp, input logic [19:0] rt);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {rt, rp};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        cfg_wen <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wen <= 1'b0;
        case (idx)
            REG_TEMP_COEF:  temp_cf = val[47:0];
            REG_PRESS_LOW:  plow_cf = val;
            REG_PRESS_HIGH: phigh_cf = val;
            default:        p9_cf = val[15:0];
        endcase
        @(posedge clk);
    endtask

    task automatic load_coefs(input logic [63:0] tw, input logic [63:0] lw,
                              input logic [63:0] hw, input logic [63:0] lastw);
        write_reg(REG_TEMP_COEF, tw);
        write_reg(REG_PRESS_LOW, lw);
        write_reg(REG_PRESS_HIGH, hw);
        write_reg(REG_PRESS_LAST, lastw);
    endtask

    task automatic random_burst(input int n, input bit typical);
        logic [19:0] rp;
        logic [19:0] rt;
        for (int i = 0; i < n; i++)
        begin
            no_idle = (i % 40) >= 30;
            if (typical && $urandom_range(0, 3) != 0)
            begin
                rp = 20'($urandom_range(250000, 650000));
                rt = 20'($urandom_range(400000, 650000));
            end
            else
            begin
                rp = 20'($urandom);
                rt = 20'($urandom);
            end
            send_reading(rp, rt);
        end
        no_idle = 1'b0;
        drain();
    endtask

    localparam logic [63:0] TYP_T = {16'd0, 16'hFC18, 16'd26435, 16'd27504};
    localparam logic [63:0] TYP_L = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
    localparam logic [63:0] TYP_H = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
    localparam logic [63:0] TYP_9 = 64'd6000;

    row_t rows[$];

    initial
    begin
        reading_t zero_res;
        zero_res.tc = '0;
        zero_res.press = '0;
        zero_res.err = 1'b1;
        // With every coefficient zero the divisor is zero for any reading.
        rows.push_back('{20'h00000, 20'h00000, 1'b1, zero_res});
        rows.push_back('{20'hFFFFF, 20'hFFFFF, 1'b1, zero_res});
        rows.push_back('{20'hFFFFF, 20'h00000, 1'b1, zero_res});
        rows.push_back('{20'h00000, 20'hFFFFF, 1'b1, zero_res});
        rows.push_back('{20'hAAAAA, 20'h55555, 1'b1, zero_res});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            literal_q.push_back(rows[i].want);
            literal_use_q.push_back(rows[i].lit);
            send_reading(rows[i].rp, rows[i].rt);
        end
        drain();

        load_coefs(TYP_T, TYP_L, TYP_H, TYP_9);
        rows.delete();
        rows.push_back('{20'd415148, 20'd519888, 1'b0, zero_res});
        rows.push_back('{20'h00000, 20'd519888, 1'b0, zero_res});
        rows.push_back('{20'hFFFFF, 20'd519888, 1'b0, zero_res});
        rows.push_back('{20'd415148, 20'h00000, 1'b0, zero_res});
        rows.push_back('{20'd415148, 20'hFFFFF, 1'b0, zero_res});
        rows.push_back('{20'd415148, 20'd300000, 1'b0, zero_res});
        rows.push_back('{20'd415148, 20'd800000, 1'b0, zero_res});
        rows.push_back('{20'd100, 20'd700000, 1'b0, zero_res});
        rows.push_back('{20'd1048000, 20'd400000, 1'b0, zero_res});
        foreach (rows[i])
        begin
            literal_q.push_back(rows[i].want);
            literal_use_q.push_back(1'b0);
            send_reading(rows[i].rp, rows[i].rt);
        end
        drain();
        random_burst(80, 1'b1);

        // Zero P1 gives a zero divisor while the temperature still works.
        load_coefs(TYP_T, {TYP_L[63:16], 16'd0}, TYP_H, TYP_9);
        random_burst(20, 1'b1);

        load_coefs(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                   64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        random_burst(30, 1'b0);

        load_coefs(64'({16'h8000, 16'h7FFF, 16'hFFFF}),
                   {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF},
                   {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 64'h7FFF);
        random_burst(30, 1'b0);

        load_coefs({16'h0000, 16'h8000, 16'h8000, 16'h0001}, {16'h8000, 16'h8000, 16'h8000, 16'h0001},
                   {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 64'h8000);
        random_burst(30, 1'b0);

        for (int k = 0; k < 4; k++)
        begin
            load_coefs({$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom}, {$urandom, $urandom});
            random_burst(30, 1'b0);
        end

        for (int k = 0; k < 2; k++)
        begin
            load_coefs({16'd0, TYP_T[47:32] ^ 16'($urandom_range(0, 255)),
                        TYP_T[31:16] ^ 16'($urandom_range(0, 1023)),
                        TYP_T[15:0] ^ 16'($urandom_range(0, 1023))},
                       {TYP_L[63:16], TYP_L[15:0] ^ 16'($urandom_range(0, 4095))},
                       TYP_H, 64'($urandom_range(0, 8000)));
            random_burst(45, 1'b1);
        end

        if (mismatches == 0 && expected_q.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
